// ===== rtl/core/tsb_pkg.sv =====
// tsb_pkg: shared constants, types and helpers for the scrollback buffer
// used by every module of the block except tsb_ram; no dependencies
package tsb_pkg;

  localparam int LINES   = 512;
  localparam int COLUMNS = 256;
  localparam int LINE_W  = $clog2(LINES);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CCOL_W  = COL_W + 1;
  localparam int ADDR_W  = LINE_W + COL_W;
  localparam int DEPTH   = LINES * COLUMNS;

  localparam int KIND_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int RGB_W   = 24;
  localparam int ROW_FW  = 9;
  localparam int COL_FW  = 8;
  localparam int CCOL_FW = 9;
  localparam int ROWS_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W   = (LINE_W > ROWS_W ? LINE_W : ROWS_W) + 1;

  localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SNAP  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_FG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_BG     = 2'd2;

  localparam logic [ROWS_W-1:0] VISIBLE_ROWS_RST = 10'd1;
  localparam logic [RGB_W-1:0]  BLANK_FG_RST     = 24'hCCDDFF;
  localparam logic [RGB_W-1:0]  BLANK_BG_RST     = 24'h050508;

  typedef enum logic [3:0] {
    OP_CHAR, OP_NEWLINE, OP_RETURN, OP_BACKSPACE, OP_UP, OP_DOWN,
    OP_READ, OP_SNAP, OP_CLEAR, OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
  } op_item_t;

  typedef struct packed {
    logic [ROWS_W-1:0] visible_rows;
    logic [RGB_W-1:0]  blank_fg;
    logic [RGB_W-1:0]  blank_bg;
  } cfg_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_BLANK, S_WIPE, S_READ, S_DONE
  } state_t;

  // lowest view line that still shows the cursor line
  function automatic logic [LINE_W-1:0] view_bottom(input logic [LINE_W-1:0] line,
                                                    input logic [ROWS_W-1:0] rows);
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] s;
    r = (rows == '0) ? SUM_W'(1) : SUM_W'(rows);
    s = SUM_W'(line) + SUM_W'(1);
    if (s <= r) return '0;
    return LINE_W'(s - r);
  endfunction

endpackage

// ===== rtl/core/tsb_if.sv =====
// tsb_if: valid/ready channels of the scrollback buffer (request, result, config)
// depends on tsb_pkg
interface tsb_req_if;
  import tsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [RGB_W-1:0]  write_fg;
  logic [RGB_W-1:0]  write_bg;
  logic [ROW_FW-1:0] read_row;
  logic [COL_FW-1:0] read_col;
  modport source (output valid, kind, char_code, write_fg, write_bg, read_row, read_col,
                  input ready);
  modport sink (input valid, kind, char_code, write_fg, write_bg, read_row, read_col,
                output ready);
endinterface

interface tsb_rsp_if;
  import tsb_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  cell_char;
  logic [RGB_W-1:0]   cell_fg;
  logic [RGB_W-1:0]   cell_bg;
  logic [ROW_FW-1:0]  cursor_row;
  logic [CCOL_FW-1:0] cursor_col;
  logic [ROW_FW-1:0]  view_top;
  logic               view_moved;
  modport source (output valid, cell_char, cell_fg, cell_bg, cursor_row, cursor_col,
                  view_top, view_moved, input ready);
  modport sink (input valid, cell_char, cell_fg, cell_bg, cursor_row, cursor_col,
                view_top, view_moved, output ready);
endinterface

interface tsb_cfg_if;
  import tsb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [RGB_W-1:0]     data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// ===== rtl/core/tsb_ram.sv =====
// tsb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module tsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/tsb_front.sv =====
// tsb_front: accepts request items and config writes, decodes items into operations
// depends on tsb_pkg and tsb_if
module tsb_front (
  input  logic                  clk,
  input  logic                  rst,
  tsb_req_if.sink               req,
  tsb_cfg_if.sink               cfg,
  input  tsb_pkg::back_status_t status,
  input  logic                  q_full,
  output logic                  q_push,
  output tsb_pkg::op_item_t     q_item,
  output tsb_pkg::cfg_t         regs
);
  import tsb_pkg::*;

  op_t op;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.visible_rows <= VISIBLE_ROWS_RST;
      regs.blank_fg     <= BLANK_FG_RST;
      regs.blank_bg     <= BLANK_BG_RST;
    end else if (cfg.valid) begin
      unique case (cfg.idx)
        REG_VISIBLE_ROWS: regs.visible_rows <= ROWS_W'(cfg.data);
        REG_BLANK_FG:     regs.blank_fg     <= cfg.data;
        REG_BLANK_BG:     regs.blank_bg     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    op = OP_NOP;
    unique case (req.kind)
      KIND_PUT: begin
        priority if (req.char_code == CH_NEWLINE)   op = OP_NEWLINE;
        else if (req.char_code == CH_RETURN)        op = OP_RETURN;
        else if (req.char_code == CH_BACKSPACE)     op = OP_BACKSPACE;
        else                                        op = OP_CHAR;
      end
      KIND_UP:    op = OP_UP;
      KIND_DOWN:  op = OP_DOWN;
      KIND_READ:  op = OP_READ;
      KIND_SNAP:  op = OP_SNAP;
      KIND_CLEAR: op = OP_CLEAR;
      default:    op = OP_NOP;
    endcase
  end

  assign req.ready = !q_full && !status.init_busy;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    q_item.op        = op;
    q_item.char_code = req.char_code;
    q_item.fg        = req.write_fg;
    q_item.bg        = req.write_bg;
    q_item.row       = req.read_row;
    q_item.col       = req.read_col;
  end
endmodule

// ===== rtl/core/tsb_queue.sv =====
// tsb_queue: two-entry queue of decoded operations between front and back
// depends on tsb_pkg
module tsb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsb_pkg::op_item_t push_item,
  input  logic              pop,
  output tsb_pkg::op_item_t head,
  output logic              empty,
  output logic              full
);
  import tsb_pkg::*;

  op_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/core/tsb_back.sv =====
// tsb_back: executes operations on the cell store, cursor and view; owns the result register
// depends on tsb_pkg, tsb_if and tsb_ram
module tsb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tsb_pkg::cfg_t          regs,
  input  tsb_pkg::op_item_t      head,
  input  logic                   q_empty,
  output logic                   q_pop,
  output tsb_pkg::back_status_t  status,
  tsb_rsp_if.source              rsp
);
  import tsb_pkg::*;

  state_t state, state_next;
  op_item_t cur;

  logic [LINE_W-1:0] line;
  logic [CCOL_W-1:0] col;
  logic [LINE_W-1:0] view;
  logic [LINE_W-1:0] ring;
  logic [ADDR_W-1:0] cnt;
  logic [RGB_W-1:0]  wipe_fg;
  logic [RGB_W-1:0]  wipe_bg;
  logic              rd_hit;
  logic              moved;
  logic [CHAR_W-1:0] res_char;
  logic [RGB_W-1:0]  res_fg;
  logic [RGB_W-1:0]  res_bg;

  logic                  char_we, colr_we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [CHAR_W-1:0]     char_wdata, char_rdata;
  logic [2*RGB_W-1:0]    colr_wdata, colr_rdata;

  logic [LINE_W-1:0] bottom;
  logic [LINE_W-1:0] nl_line, nl_ring, nl_view_pre, nl_view;
  logic [COL_W-1:0]  col_lo, col_back;
  logic              wrap, line_end, sweep_end, out_free;

  assign bottom    = view_bottom(line, regs.visible_rows);
  assign wrap      = (col == CCOL_W'(COLUMNS));
  assign col_lo    = col[COL_W-1:0];
  assign col_back  = COL_W'(col - CCOL_W'(1));
  assign line_end  = (cnt[COL_W-1:0] == COL_W'(COLUMNS - 1));
  assign sweep_end = (cnt == ADDR_W'(DEPTH - 1));
  assign out_free  = !rsp.valid || rsp.ready;

  // newline: scroll the ring when already on the last line
  always_comb begin
    if (line == LINE_W'(LINES - 1)) begin
      nl_line     = line;
      nl_ring     = ring + LINE_W'(1);
      nl_view_pre = (view != '0) ? view - LINE_W'(1) : view;
    end else begin
      nl_line     = line + LINE_W'(1);
      nl_ring     = ring;
      nl_view_pre = view;
    end
    nl_view = nl_view_pre;
    if (nl_view_pre < view_bottom(nl_line, regs.visible_rows)) begin
      nl_view = view_bottom(nl_line, regs.visible_rows);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  if (sweep_end) state_next = S_IDLE;
      S_IDLE:  if (!q_empty) state_next = S_EXEC;
      S_EXEC: begin
        unique case (cur.op)
          OP_NEWLINE: state_next = S_BLANK;
          OP_CHAR:    state_next = wrap ? S_BLANK : S_DONE;
          OP_READ:    state_next = S_READ;
          OP_CLEAR:   state_next = S_WIPE;
          default:    state_next = S_DONE;
        endcase
      end
      S_BLANK: if (line_end) state_next = (cur.op == OP_CHAR) ? S_EXEC : S_DONE;
      S_WIPE:  if (sweep_end) state_next = S_DONE;
      S_READ:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  // memory controls, queue pop and init status
  always_comb begin
    char_we    = 1'b0;
    colr_we    = 1'b0;
    waddr      = cnt;
    char_wdata = CH_SPACE;
    colr_wdata = {wipe_fg, wipe_bg};
    raddr      = {LINE_W'(ring + LINE_W'(cur.row)), COL_W'(cur.col)};
    q_pop      = (state == S_IDLE) && !q_empty;
    status.init_busy = (state == S_INIT);
    unique case (state)
      S_INIT, S_WIPE: begin
        char_we = 1'b1;
        colr_we = 1'b1;
      end
      S_BLANK: begin
        char_we = 1'b1;
        colr_we = 1'b1;
        waddr   = {LINE_W'(ring + line), cnt[COL_W-1:0]};
      end
      S_EXEC: begin
        if (cur.op == OP_CHAR && !wrap) begin
          char_we    = 1'b1;
          colr_we    = 1'b1;
          waddr      = {LINE_W'(ring + line), col_lo};
          char_wdata = cur.char_code;
          colr_wdata = {cur.fg, cur.bg};
        end else if (cur.op == OP_BACKSPACE && col != '0) begin
          char_we = 1'b1;
          waddr   = {LINE_W'(ring + line), col_back};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= '0;
      col       <= '0;
      view      <= '0;
      ring      <= '0;
      cnt       <= '0;
      wipe_fg   <= BLANK_FG_RST;
      wipe_bg   <= BLANK_BG_RST;
      rsp.valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready)              rsp.valid <= 1'b0;
      unique case (state)
        S_INIT, S_WIPE: cnt <= cnt + ADDR_W'(1);
        S_BLANK:        cnt <= cnt + ADDR_W'(1);
        S_IDLE: begin
          if (!q_empty) cur <= head;
        end
        S_EXEC: begin
          moved    <= 1'b0;
          res_char <= '0;
          res_fg   <= '0;
          res_bg   <= '0;
          unique case (cur.op)
            OP_CHAR: begin
              if (wrap) begin
                line    <= nl_line;
                ring    <= nl_ring;
                view    <= nl_view;
                col     <= '0;
                cnt     <= '0;
                wipe_fg <= regs.blank_fg;
                wipe_bg <= regs.blank_bg;
              end else begin
                col <= col + CCOL_W'(1);
                if (view < bottom) view <= bottom;
              end
            end
            OP_NEWLINE: begin
              line    <= nl_line;
              ring    <= nl_ring;
              view    <= nl_view;
              col     <= '0;
              cnt     <= '0;
              wipe_fg <= regs.blank_fg;
              wipe_bg <= regs.blank_bg;
            end
            OP_RETURN: col <= '0;
            OP_BACKSPACE: if (col != '0) col <= col - CCOL_W'(1);
            OP_UP: begin
              if (view != '0) begin
                view  <= view - LINE_W'(1);
                moved <= 1'b1;
              end
            end
            OP_DOWN: begin
              if (view < bottom) begin
                view  <= view + LINE_W'(1);
                moved <= 1'b1;
              end
            end
            OP_READ: rd_hit <= (32'(cur.row) < LINES) && (32'(cur.col) < COLUMNS);
            OP_SNAP: view <= bottom;
            OP_CLEAR: begin
              line    <= '0;
              col     <= '0;
              view    <= '0;
              ring    <= '0;
              cnt     <= '0;
              wipe_fg <= regs.blank_fg;
              wipe_bg <= regs.blank_bg;
            end
            default: ;
          endcase
        end
        S_READ: begin
          if (rd_hit) begin
            res_char <= char_rdata;
            {res_fg, res_bg} <= colr_rdata;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.cell_char  <= res_char;
            rsp.cell_fg    <= res_fg;
            rsp.cell_bg    <= res_bg;
            rsp.cursor_row <= ROW_FW'(line);
            rsp.cursor_col <= CCOL_FW'(col);
            rsp.view_top   <= ROW_FW'(view);
            rsp.view_moved <= moved;
          end
        end
        default: ;
      endcase
    end
  end

  tsb_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_char_ram (
    .clk(clk), .we(char_we), .waddr(waddr), .wdata(char_wdata),
    .raddr(raddr), .rdata(char_rdata)
  );

  tsb_ram #(.WIDTH(2*RGB_W), .DEPTH(DEPTH)) u_colr_ram (
    .clk(clk), .we(colr_we), .waddr(waddr), .wdata(colr_wdata),
    .raddr(raddr), .rdata(colr_rdata)
  );
endmodule

// ===== rtl/core/terminal_scrollback_buffer_unit.sv =====
// terminal_scrollback_buffer_unit: top level of the character-cell scrollback buffer
// depends on tsb_pkg, tsb_if, tsb_front, tsb_queue, tsb_back
//
// Channels: req carries one item (kind, char_code, write colours, read_row/read_col),
// rsp returns exactly one result per item, cfg writes visible_rows (0), blank_fg (1)
// and blank_bg (2). All use valid/ready; a transfer happens when both are high.
// The cell store is 512 lines of 256 cells held as a ring of physical lines.
// Between acceptance and rsp.valid an item passes the queue and the back end's IDLE,
// EXEC and DONE states; ordinary characters, return, backspace, view moves, snap and
// the spare kinds need no more; a cell read adds a READ state, as the RAM read is
// registered; a newline adds a BLANK pass that blanks the new line one cell per cycle,
// a wrapping character makes the same pass before its cell is written, and a clear
// adds a WIPE pass over the store, one cell per cycle. The back end carries out items
// one at a time; a two-entry queue lets the front take up to two further items
// meanwhile. After reset the store is blanked cell by cell while req.ready stays low;
// configuration writes are taken throughout. When rsp is stalled the result stays in
// the output register, the back end waits, and once the queue is full req.ready drops.
module terminal_scrollback_buffer_unit (
  input  logic     clk,
  input  logic     rst,
  tsb_cfg_if.sink  cfg,
  tsb_req_if.sink  req,
  tsb_rsp_if.source rsp
);
  import tsb_pkg::*;

  back_status_t status;
  cfg_t         regs;
  op_item_t     push_item, head;
  logic         q_push, q_pop, q_empty, q_full;

  tsb_front u_front (
    .clk(clk), .rst(rst), .req(req), .cfg(cfg), .status(status),
    .q_full(q_full), .q_push(q_push), .q_item(push_item), .regs(regs)
  );

  tsb_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(push_item),
    .pop(q_pop), .head(head), .empty(q_empty), .full(q_full)
  );

  tsb_back u_back (
    .clk(clk), .rst(rst), .regs(regs), .head(head), .q_empty(q_empty),
    .q_pop(q_pop), .status(status), .rsp(rsp)
  );
endmodule

// ===== rtl/core/tsb_checker.sv =====
// tsb_checker: port-level assertions on the scrollback buffer, bound to the top level
// depends on tsb_pkg
module tsb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic [tsb_pkg::ROW_FW-1:0]  cursor_row,
  input logic [tsb_pkg::CCOL_FW-1:0] cursor_col,
  input logic [tsb_pkg::ROW_FW-1:0]  view_top,
  input logic                        view_moved,
  input logic [tsb_pkg::CHAR_W-1:0]  cell_char
);
  import tsb_pkg::*;

  // the store wipe after reset holds off items
  a_init_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item accepted during reset wipe");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(cursor_col) <= COLUMNS))
    else $error("cursor column out of range");

  a_view_above_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (view_top <= cursor_row))
    else $error("view top below cursor line");

  a_moved_no_cell: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && view_moved) |-> (cell_char == '0))
    else $error("view move item carries cell data");
endmodule

bind terminal_scrollback_buffer_unit tsb_checker u_tsb_checker (
  .clk(clk), .rst(rst), .req_ready(req.ready), .rsp_valid(rsp.valid),
  .cursor_row(rsp.cursor_row), .cursor_col(rsp.cursor_col), .view_top(rsp.view_top),
  .view_moved(rsp.view_moved), .cell_char(rsp.cell_char)
);

// ===== test/terminal_scrollback_buffer_unit_tb.sv =====
// testbench for terminal_scrollback_buffer_unit: directed and random items with a local
// scrollback predictor checked field by field; depends on tsb_pkg, tsb_if and the rtl
`timescale 1ns / 100ps

module terminal_scrollback_buffer_unit_tb;
  import tsb_pkg::*;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
  } term_item_t;

  typedef struct {
    logic [CHAR_W-1:0]  cell_char;
    logic [RGB_W-1:0]   cell_fg;
    logic [RGB_W-1:0]   cell_bg;
    logic [ROW_FW-1:0]  cursor_row;
    logic [CCOL_FW-1:0] cursor_col;
    logic [ROW_FW-1:0]  view_top;
    logic               view_moved;
  } term_view_t;

  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsb_cfg_if cfg_ch ();
  tsb_req_if req_ch ();
  tsb_rsp_if rsp_ch ();

  terminal_scrollback_buffer_unit dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch), .req(req_ch), .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [55:0]        shadow_cells [DEPTH];
  int unsigned        cur_line, cur_col, view_line, ring_base;
  logic [ROWS_W-1:0]  rows_reg;
  logic [RGB_W-1:0]   blank_fg_reg, blank_bg_reg;

  term_view_t  expected_views[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          hold_left = 0;

  function automatic int unsigned phys_index(int unsigned line, int unsigned c);
    int unsigned p;
    p = ring_base + line;
    if (p >= LINES) p -= LINES;
    return p * COLUMNS + c;
  endfunction

  function automatic void blank_row(int unsigned line);
    for (int c = 0; c < COLUMNS; c++)
      shadow_cells[phys_index(line, c)] = {CH_SPACE, blank_fg_reg, blank_bg_reg};
  endfunction

  function automatic void wipe_all();
    cur_line = 0; cur_col = 0; view_line = 0; ring_base = 0;
    for (int r = 0; r < LINES; r++) blank_row(r);
  endfunction

  function automatic int unsigned bottom_line();
    int unsigned rows;
    rows = (rows_reg == '0) ? 1 : rows_reg;
    if (cur_line + 1 <= rows) return 0;
    return cur_line + 1 - rows;
  endfunction

  function automatic void follow_bottom();
    if (view_line < bottom_line()) view_line = bottom_line();
  endfunction

  function automatic void advance_line();
    cur_line++;
    if (cur_line >= LINES) begin
      ring_base = (ring_base + 1) % LINES;
      cur_line = LINES - 1;
      if (view_line > 0) view_line--;
    end
    blank_row(cur_line);
    cur_col = 0;
    follow_bottom();
  endfunction

  function automatic term_view_t apply_item(term_item_t it);
    term_view_t v;
    logic [55:0] entry;
    v = '{default: '0};
    case (it.kind)
      KIND_PUT: begin
        if (it.ch == CH_NEWLINE) advance_line();
        else if (it.ch == CH_RETURN) cur_col = 0;
        else if (it.ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_cells[phys_index(cur_line, cur_col)][55:48] = CH_SPACE;
          end
        end else begin
          if (cur_col >= COLUMNS) advance_line();
          shadow_cells[phys_index(cur_line, cur_col)] = {it.ch, it.fg, it.bg};
          cur_col++;
          follow_bottom();
        end
      end
      KIND_UP: if (view_line > 0) begin
        view_line--; v.view_moved = 1'b1;
      end
      KIND_DOWN: if (view_line < bottom_line()) begin
        view_line++; v.view_moved = 1'b1;
      end
      KIND_READ: if (it.row < LINES && it.col < COLUMNS) begin
        entry = shadow_cells[phys_index(it.row, it.col)];
        {v.cell_char, v.cell_fg, v.cell_bg} = entry;
      end
      KIND_SNAP: view_line = bottom_line();
      KIND_CLEAR: wipe_all();
      default: ;
    endcase
    v.cursor_row = cur_line[ROW_FW-1:0];
    v.cursor_col = cur_col[CCOL_FW-1:0];
    v.view_top   = view_line[ROW_FW-1:0];
    return v;
  endfunction

  function automatic term_item_t make_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] c,
                                           logic [RGB_W-1:0] fg, logic [RGB_W-1:0] bg,
                                           logic [ROW_FW-1:0] r, logic [COL_FW-1:0] col);
    term_item_t it;
    it.kind = k; it.ch = c; it.fg = fg; it.bg = bg; it.row = r; it.col = col;
    return it;
  endfunction

  // random and control bytes, view moves, snaps, spare kinds, reads near written area
  function automatic term_item_t random_item(int newline_pct);
    term_item_t it;
    int unsigned pick;
    it = make_item(KIND_PUT, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      pick = $urandom_range(99);
      if (pick < newline_pct) it.ch = CH_NEWLINE;
      else if (pick < newline_pct + 4) it.ch = CH_RETURN;
      else if (pick < newline_pct + 10) it.ch = CH_BACKSPACE;
    end else if (pick < 63) it.kind = KIND_UP;
    else if (pick < 71) it.kind = KIND_DOWN;
    else if (pick < 93) begin
      it.kind = KIND_READ;
      if ($urandom_range(9) < 7) begin
        it.row = $urandom_range(cur_line);
        it.col = (cur_col > 0 && $urandom_range(1)) ? $urandom_range(cur_col - 1) : $urandom;
      end
    end else if (pick < 98) it.kind = KIND_SNAP;
    else it.kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
    return it;
  endfunction

  task automatic send_item(term_item_t it);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 7) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.kind = it.kind; req_ch.char_code = it.ch;
    req_ch.write_fg = it.fg; req_ch.write_bg = it.bg;
    req_ch.read_row = it.row; req_ch.read_col = it.col;
    req_ch.valid = 1'b1;
    forever begin
      #0.9;
      if (req_ch.ready) begin
        @(posedge clk);
        break;
      end
      @(negedge clk);
    end
    expected_views.push_back(apply_item(it));
  endtask

  // lower valid and wait until every result is back
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RGB_W-1:0] data);
    @(negedge clk);
    cfg_ch.idx = idx; cfg_ch.data = data; cfg_ch.valid = 1'b1;
    forever begin
      #0.9;
      if (cfg_ch.ready) begin
        @(posedge clk);
        break;
      end
      @(negedge clk);
    end
    case (idx)
      REG_VISIBLE_ROWS: rows_reg = data[ROWS_W-1:0];
      REG_BLANK_FG: blank_fg_reg = data;
      REG_BLANK_BG: blank_bg_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic check_view();
    term_view_t e;
    if (expected_views.size() == 0) begin
      $error("result with no item outstanding");
      errors++;
      return;
    end
    e = expected_views.pop_front();
    if (rsp_ch.cell_char !== e.cell_char) begin
      $error("cell_char exp %0h got %0h", e.cell_char, rsp_ch.cell_char); errors++;
    end
    if (rsp_ch.cell_fg !== e.cell_fg) begin
      $error("cell_fg exp %0h got %0h", e.cell_fg, rsp_ch.cell_fg); errors++;
    end
    if (rsp_ch.cell_bg !== e.cell_bg) begin
      $error("cell_bg exp %0h got %0h", e.cell_bg, rsp_ch.cell_bg); errors++;
    end
    if (rsp_ch.cursor_row !== e.cursor_row) begin
      $error("cursor_row exp %0d got %0d", e.cursor_row, rsp_ch.cursor_row); errors++;
    end
    if (rsp_ch.cursor_col !== e.cursor_col) begin
      $error("cursor_col exp %0d got %0d", e.cursor_col, rsp_ch.cursor_col); errors++;
    end
    if (rsp_ch.view_top !== e.view_top) begin
      $error("view_top exp %0d got %0d", e.view_top, rsp_ch.view_top); errors++;
    end
    if (rsp_ch.view_moved !== e.view_moved) begin
      $error("view_moved exp %0b got %0b", e.view_moved, rsp_ch.view_moved); errors++;
    end
  endtask

  // result side: random stalls, or a counted hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = quiet || ($urandom_range(99) >= 7);
      end
      #0.9;
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_view();
    end
  end

  task automatic test_directed();
    send_item(make_item(KIND_UP, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_DOWN, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 9'h1FF, 8'hFF));
    send_item(make_item(KIND_PUT, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    send_item(make_item(KIND_PUT, 8'h00, 24'h000000, 24'h000000, 0, 0));
    send_item(make_item(KIND_PUT, "A", 24'h123456, 24'hABCDEF, 0, 0));
    send_item(make_item(KIND_PUT, CH_BACKSPACE, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 2));
    send_item(make_item(KIND_PUT, CH_RETURN, 0, 0, 0, 0));
    send_item(make_item(KIND_PUT, CH_BACKSPACE, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_PUT, CH_NEWLINE, 0, 0, 0, 0));
    send_item(make_item(KIND_PUT, CH_NEWLINE, 0, 0, 0, 0));
    send_item(make_item(KIND_UP, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_UP, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_DOWN, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_SNAP, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_SPARE6, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 9'h1FF, 8'hFF));
    send_item(make_item(KIND_SPARE7, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 1, 0));
    drain();
  endtask

  // a full line of characters, then one more wraps onto the next line
  task automatic test_wrap();
    write_reg(REG_VISIBLE_ROWS, 0);
    send_item(make_item(KIND_PUT, CH_RETURN, 0, 0, 0, 0));
    for (int i = 0; i < COLUMNS + 1; i++)
      send_item(make_item(KIND_PUT, 8'h21 + (i % 90), $urandom, $urandom, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, cur_line - 1, 8'hFF));
    send_item(make_item(KIND_READ, 0, 0, 0, cur_line, 0));
    send_item(make_item(KIND_UP, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_SNAP, 0, 0, 0, 0, 0));
    drain();
  endtask

  // enough lines to reach the bottom of the store and scroll it
  task automatic test_scroll();
    write_reg(REG_VISIBLE_ROWS, 3);
    write_reg(REG_BLANK_FG, 24'h00FF00);
    for (int i = 0; i < LINES + 8; i++) begin
      if (i % 16 == 0) send_item(make_item(KIND_PUT, "x", $urandom, $urandom, 0, 0));
      send_item(make_item(KIND_PUT, CH_NEWLINE, 0, 0, 0, 0));
    end
    for (int i = 0; i < 6; i++) send_item(make_item(KIND_UP, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_PUT, CH_NEWLINE, 0, 0, 0, 0));
    send_item(make_item(KIND_DOWN, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 9'h1FF, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 9'h1F0, 0));
    drain();
  endtask

  task automatic test_random_phase(logic [ROWS_W-1:0] rows, logic [RGB_W-1:0] fg,
                                   logic [RGB_W-1:0] bg, int count, int newline_pct);
    write_reg(REG_VISIBLE_ROWS, rows);
    write_reg(REG_BLANK_FG, fg);
    write_reg(REG_BLANK_BG, bg);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 2) && (i < count / 2 + 40);
      send_item(random_item(newline_pct));
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_clear();
    write_reg(REG_BLANK_FG, 24'hFFFFFF);
    write_reg(REG_BLANK_BG, 24'h000000);
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 9'h1FF, 8'hFF));
    send_item(make_item(KIND_PUT, "z", 24'h010203, 24'h040506, 0, 0));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
    drain();
  endtask

  // result side held off while items keep coming, so the input stalls
  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 30; i++) send_item(random_item(0));
    drain();
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.idx = '0; cfg_ch.data = '0;
    req_ch.valid = 1'b0; req_ch.kind = '0; req_ch.char_code = '0;
    req_ch.write_fg = '0; req_ch.write_bg = '0; req_ch.read_row = '0; req_ch.read_col = '0;
    rows_reg = VISIBLE_ROWS_RST;
    blank_fg_reg = BLANK_FG_RST;
    blank_bg_reg = BLANK_BG_RST;
    wipe_all();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_wrap();
    test_scroll();
    test_random_phase(10'd512, 24'h000000, 24'hFFFFFF, 70, 6);
    test_backpressure();
    test_clear();
    test_random_phase(10'd1, $urandom, $urandom, 50, 10);
    test_random_phase(10'd0, 24'hFFFFFF, 24'h000000, 40, 10);
    test_random_phase(10'd1023, $urandom, $urandom, 30, 8);
    test_random_phase(10'd7, $urandom, $urandom, 40, 12);

    repeat (40) @(posedge clk);
    if (expected_views.size() != 0) errors++;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tsb_pkg.sv
rtl/core/tsb_if.sv
rtl/core/tsb_ram.sv
rtl/core/tsb_front.sv
rtl/core/tsb_queue.sv
rtl/core/tsb_back.sv
rtl/core/terminal_scrollback_buffer_unit.sv
rtl/core/tsb_checker.sv
test/terminal_scrollback_buffer_unit_tb.sv
